// ===== src/swm_pkg.sv =====
// Shared constants and types for the sliding window median block.
package swm_pkg;

    // Default build values
    localparam int MAX_WINDOW_DEF   = 16;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Port and register widths
    localparam int SAMPLE_PORT_W = 32;
    localparam int MEDIAN_W      = 33;
    localparam int WIN_W         = 5;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    // Register map (word index taken from paddr[2])
    localparam logic REG_WINDOW = 1'b0;

    // Reset value of the window size register
    localparam logic [WIN_W-1:0] WIN_RESET = 5'd3;

    // Control that ripples from a cell to its right neighbor
    typedef struct packed {
        logic rm_le;   // an entry is removed at or left of this cell
        logic take;    // the insert position is at or left of this cell
    } t_cell_ctl;

endpackage

// ===== src/swm_cell.sv =====
// One cell of the sorted chain: holds one sample and its age.
module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int AGE_W        = 4,
    parameter int FILL_W       = 5
) (
    input  logic                    i_clk,
    input  logic                    i_update,
    input  logic                    i_insert,
    input  logic [FILL_W-1:0]       i_win,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_own_valid,
    // raw contents of the right neighbor
    input  logic                    i_right_valid,
    input  logic [SAMPLE_WIDTH-1:0] i_right_value,
    input  logic [AGE_W-1:0]        i_right_age,
    // compacted contents and control of the left neighbor
    input  logic [SAMPLE_WIDTH-1:0] i_left_cvalue,
    input  logic [AGE_W-1:0]        i_left_cage,
    input  t_cell_ctl               i_left_ctl,
    // own stored contents
    output logic [SAMPLE_WIDTH-1:0] o_value,
    output logic [AGE_W-1:0]        o_age,
    // own compacted contents and control for the right neighbor
    output logic [SAMPLE_WIDTH-1:0] o_cvalue,
    output logic [AGE_W-1:0]        o_cage,
    output t_cell_ctl               o_ctl
);

    logic [SAMPLE_WIDTH-1:0] r_value, n_value;
    logic [AGE_W-1:0]        r_age, n_age;
    logic [FILL_W-1:0]       age_p1;
    logic                    aged_out;
    logic                    greater;
    logic                    cvalid;

    // Entry leaves the window once its age reaches window - 1
    assign age_p1   = FILL_W'(r_age) + FILL_W'(1);
    assign aged_out = i_own_valid && (age_p1 >= i_win);

    // Remove only the leftmost aged-out entry; shift left behind it
    assign o_ctl.rm_le = i_left_ctl.rm_le | aged_out;
    assign cvalid      = o_ctl.rm_le ? i_right_valid : i_own_valid;
    assign o_cvalue    = o_ctl.rm_le ? i_right_value : r_value;
    assign o_cage      = o_ctl.rm_le ? i_right_age   : r_age;

    // Insert position: first compacted slot that is empty or holds a larger value
    assign greater     = $signed(o_cvalue) > $signed(i_sample);
    assign o_ctl.take  = !cvalid || greater;

    // Next contents
    always_comb begin
        n_value = o_cvalue;
        n_age   = o_cage;
        if (i_insert) begin
            if (!o_ctl.take) begin
                n_value = o_cvalue;
                n_age   = o_cage + AGE_W'(1);
            end else if (i_left_ctl.take) begin
                n_value = i_left_cvalue;
                n_age   = i_left_cage + AGE_W'(1);
            end else begin
                n_value = i_sample;
                n_age   = '0;
            end
        end
    end

    // Payload storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_update) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

    assign o_value = r_value;
    assign o_age   = r_age;

endmodule

// ===== src/sliding_window_median.sv =====
// Top level of the sliding window median filter: control, register port and output stage.
//
// Usage:
//   Samples enter on i_valid/o_ready with i_sample and i_restart; one beat per sample.
//   i_restart empties the window before its sample is taken.
//   Once the window holds window_size samples, every sample gives one result beat on
//   o_valid/i_ready carrying o_median_x2, twice the median of the window.
//   Before that, samples give no result.
//   o_valid rises once the result flag set on acceptance loads the output register.
//   Throughput: one sample per cycle unless held (see below). Each sample is sorted into
//   a row of cells: the oldest entry drops out and the new one slides into place.
//   After window_size is lowered with more samples stored than the new window, the
//   next sample waits while the chain removes the surplus entries, one per cycle
//   while that sample is offered (a restarting sample waits for none).
//   Reset (synchronous, active low) empties the window, sets window_size to 3 and
//   clears the output stage. window_size lives at APB byte address 0. The user must
//   see that it is written only while the block is idle; the block does not enforce this.
//   When the receiver stalls, one result is held in the output register; the next
//   sample is still taken, but a second finished result holds the chain until the
//   first is taken.
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // sample channel
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [SAMPLE_PORT_W-1:0]   i_sample,
    input  logic                       i_restart,
    // result channel
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [MEDIAN_W-1:0] o_median_x2,
    // register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int AGE_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int IDX_W  = AGE_W;

    logic [WIN_W-1:0]  r_win_size;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              r_emit, n_emit;
    logic              r_out_valid, n_out_valid;
    logic signed [MEDIAN_W-1:0] r_median, n_median;

    logic [31:0]       win_wide, win_clamp;
    logic [FILL_W-1:0] win_eff;
    logic [FILL_W-1:0] fill_base;
    logic              need_drop, blocked, accept, drop_cyc, update, load;
    logic              cfg_wr;

    logic [SAMPLE_WIDTH-1:0] sample_s;
    logic [SAMPLE_WIDTH-1:0] cell_value  [MAX_WINDOW];
    logic [AGE_W-1:0]        cell_age    [MAX_WINDOW];
    logic [SAMPLE_WIDTH-1:0] cell_cvalue [MAX_WINDOW];
    logic [AGE_W-1:0]        cell_cage   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]   own_valid;
    t_cell_ctl               cell_ctl    [MAX_WINDOW];
    logic                    any_rm;

    logic [IDX_W-1:0]        idx_hi, idx_lo;
    logic [SAMPLE_WIDTH-1:0] mid_hi, mid_lo;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW);
    assign prdata = (paddr[2] == REG_WINDOW) ? {(APB_DW - WIN_W)'(0), r_win_size} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= WIN_RESET;
        end else if (cfg_wr) begin
            r_win_size <= pwdata[WIN_W-1:0];
        end
    end

    // Effective window: zero acts as one, large values as the cell count
    always_comb begin
        win_wide = {(32 - WIN_W)'(0), r_win_size};
        if (win_wide == 32'd0) begin
            win_clamp = 32'd1;
        end else if (win_wide > 32'(MAX_WINDOW)) begin
            win_clamp = 32'(MAX_WINDOW);
        end else begin
            win_clamp = win_wide;
        end
    end
    assign win_eff = win_clamp[FILL_W-1:0];

    // Handshake control
    assign need_drop = r_fill > win_eff;
    assign load      = r_emit && (!r_out_valid || i_ready);
    assign blocked   = r_emit && !load;
    assign o_ready   = !blocked && (!need_drop || i_restart);
    assign accept    = i_valid && o_ready;
    assign drop_cyc  = i_valid && !blocked && need_drop && !i_restart;
    assign update    = accept || drop_cyc;
    assign fill_base = (i_valid && i_restart) ? '0 : r_fill;
    assign sample_s  = i_sample[SAMPLE_WIDTH-1:0];

    // Valid entries are the first fill_base cells
    always_comb begin
        for (int j = 0; j < MAX_WINDOW; j++) begin
            own_valid[j] = FILL_W'(j) < fill_base;
        end
    end

    // Sorted chain of cells
    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++) begin : g_cell
            logic                    right_valid;
            logic [SAMPLE_WIDTH-1:0] right_value;
            logic [AGE_W-1:0]        right_age;
            logic [SAMPLE_WIDTH-1:0] left_cvalue;
            logic [AGE_W-1:0]        left_cage;
            t_cell_ctl               left_ctl;

            if (g == MAX_WINDOW - 1) begin : g_last
                assign right_valid = 1'b0;
                assign right_value = '0;
                assign right_age   = '0;
            end else begin : g_mid
                assign right_valid = own_valid[g+1];
                assign right_value = cell_value[g+1];
                assign right_age   = cell_age[g+1];
            end

            if (g == 0) begin : g_first
                assign left_cvalue = '0;
                assign left_cage   = '0;
                assign left_ctl    = '0;
            end else begin : g_rest
                assign left_cvalue = cell_cvalue[g-1];
                assign left_cage   = cell_cage[g-1];
                assign left_ctl    = cell_ctl[g-1];
            end

            swm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH),
                .AGE_W        (AGE_W),
                .FILL_W       (FILL_W)
            ) u_cell (
                .i_clk         (i_clk),
                .i_update      (update),
                .i_insert      (accept),
                .i_win         (win_eff),
                .i_sample      (sample_s),
                .i_own_valid   (own_valid[g]),
                .i_right_valid (right_valid),
                .i_right_value (right_value),
                .i_right_age   (right_age),
                .i_left_cvalue (left_cvalue),
                .i_left_cage   (left_cage),
                .i_left_ctl    (left_ctl),
                .o_value       (cell_value[g]),
                .o_age         (cell_age[g]),
                .o_cvalue      (cell_cvalue[g]),
                .o_cage        (cell_cage[g]),
                .o_ctl         (cell_ctl[g])
            );
        end
    endgenerate

    assign any_rm = cell_ctl[MAX_WINDOW-1].rm_le;

    // Fill count and result flag
    always_comb begin
        n_fill = r_fill;
        n_emit = load ? 1'b0 : r_emit;
        if (accept) begin
            n_fill = fill_base - FILL_W'(any_rm) + FILL_W'(1);
            n_emit = (n_fill == win_eff);
        end else if (drop_cyc) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    // Median taps from the settled chain
    assign idx_hi = IDX_W'(win_eff >> 1);
    assign idx_lo = win_eff[0] ? idx_hi : idx_hi - IDX_W'(1);
    assign mid_hi = cell_value[idx_hi];
    assign mid_lo = cell_value[idx_lo];

    // Output stage
    always_comb begin
        n_median    = r_median;
        n_out_valid = r_out_valid && !i_ready;
        if (load) begin
            n_median    = MEDIAN_W'($signed(mid_lo)) + MEDIAN_W'($signed(mid_hi));
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_median <= n_median;
    end

    assign o_valid     = r_out_valid;
    assign o_median_x2 = r_median;

endmodule

// ===== verif/tb_sliding_window_median.sv =====
// Self-checking testbench for the sliding window median filter.
module tb_sliding_window_median;
    import swm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W        = MAX_WINDOW_DEF;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_PHASES   = 14;
    localparam int PHASE_ITEMS  = 120;
    localparam int PAUSE_AT     = 60;
    localparam int FIXED_WINS   = 8;
    localparam int PHASE_WIN [FIXED_WINS] = '{16, 1, 31, 0, 2, 17, 15, 8};

    // Register index past the end of the map; writes there must be dropped
    localparam logic REG_SPARE = 1'b1;

    typedef enum logic {ROW_SAMPLE, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic                reg_idx;
        logic [31:0]         data;     // sample, or register value
        logic                restart;
        logic                known;    // want holds a hand-computed result
        logic [MEDIAN_W-1:0] want;
    } t_stim_row;

    localparam int NUM_ROWS = 31;
    localparam t_stim_row DIRECTED [NUM_ROWS] = '{
        // reset window of 3: positive and negative full scale
        '{ROW_SAMPLE, REG_WINDOW, 32'h7FFF_FFFF, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h7FFF_FFFF, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h7FFF_FFFF, 1'b0, 1'b1, 33'h0_FFFF_FFFE},
        '{ROW_SAMPLE, REG_WINDOW, 32'h8000_0000, 1'b0, 1'b1, 33'h0_FFFF_FFFE},
        '{ROW_SAMPLE, REG_WINDOW, 32'h8000_0000, 1'b0, 1'b1, 33'h1_0000_0000},
        '{ROW_SAMPLE, REG_WINDOW, 32'h8000_0000, 1'b0, 1'b1, 33'h1_0000_0000},
        // restart, then refill around zero
        '{ROW_SAMPLE, REG_WINDOW, 32'h0000_0000, 1'b1, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'hFFFF_FFFF, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h0000_0001, 1'b0, 1'b1, 33'h0},
        // duplicates leave by age
        '{ROW_SAMPLE, REG_WINDOW, 32'h0000_0005, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h0000_0005, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h0000_0005, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h0000_0005, 1'b1, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'hFFFF_FFFB, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h0000_FFFF, 1'b0, 1'b0, 33'h0},
        // write past the register map has no effect
        '{ROW_REG,    REG_SPARE,  32'h0000_0001, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h0000_0006, 1'b0, 1'b0, 33'h0},
        // window of one with restart gives a result at once
        '{ROW_REG,    REG_WINDOW, 32'h0000_0001, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h0000_002A, 1'b1, 1'b1, 33'd84},
        '{ROW_SAMPLE, REG_WINDOW, 32'hFFFF_FFFD, 1'b0, 1'b1, 33'h1_FFFF_FFFA},
        // grow to an even window
        '{ROW_REG,    REG_WINDOW, 32'h0000_0004, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h0000_0001, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h0000_0002, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h0000_0003, 1'b0, 1'b0, 33'h0},
        // shrink while full
        '{ROW_REG,    REG_WINDOW, 32'h0000_0002, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h0000_000A, 1'b0, 1'b0, 33'h0},
        // zero behaves as one
        '{ROW_REG,    REG_WINDOW, 32'h0000_0000, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h0000_0007, 1'b0, 1'b1, 33'd14},
        // oversize behaves as the maximum window
        '{ROW_REG,    REG_WINDOW, 32'h0000_001F, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h8000_0000, 1'b0, 1'b0, 33'h0},
        '{ROW_SAMPLE, REG_WINDOW, 32'h7FFF_FFFF, 1'b0, 1'b0, 33'h0}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [SAMPLE_PORT_W-1:0]   i_sample;
    logic                       i_restart;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [MEDIAN_W-1:0] o_median_x2;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_AW-1:0]          paddr;
    logic [APB_DW-1:0]          pwdata;
    logic [APB_DW-1:0]          prdata;
    logic                       pready;

    // Mirror of the window: ascending values, each with its age
    logic signed [31:0] win_vals [MAX_W];
    int                 win_age  [MAX_W];
    int                 win_fill;
    logic [WIN_W-1:0]   win_size_reg;

    logic signed [MEDIAN_W-1:0] pending_medians [$];
    int                         error_cnt;
    int                         cycle_cnt;
    bit                         tx_idle_on;
    bit                         rx_idle_on;
    int                         rx_stall_left;

    sliding_window_median uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_median_x2 (o_median_x2),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Slide the window by one sample; returns 1 with twice the median once full
    function automatic bit slide_window(input logic signed [31:0] smp, input logic restart,
                                        output logic signed [MEDIAN_W-1:0] mx2);
        int w;
        int kept;
        int pos;
        int i;
        w = (win_size_reg == 0) ? 1 : ((win_size_reg > MAX_W) ? MAX_W : int'(win_size_reg));
        if (restart) begin
            win_fill = 0;
        end
        // drop entries too old for the window, age the rest
        kept = 0;
        for (i = 0; i < win_fill; i++) begin
            if (win_age[i] + 1 < w && kept < w - 1) begin
                win_vals[kept] = win_vals[i];
                win_age[kept]  = win_age[i] + 1;
                kept++;
            end
        end
        // sorted insert of the new sample
        pos = kept;
        while (pos > 0 && win_vals[pos-1] > smp) begin
            win_vals[pos] = win_vals[pos-1];
            win_age[pos]  = win_age[pos-1];
            pos--;
        end
        win_vals[pos] = smp;
        win_age[pos]  = 0;
        win_fill      = kept + 1;
        mx2 = '0;
        if (win_fill != w) begin
            return 1'b0;
        end
        if (w % 2 == 1) begin
            mx2 = {win_vals[w/2], 1'b0};
        end else begin
            mx2 = {win_vals[w/2-1][31], win_vals[w/2-1]} + {win_vals[w/2][31], win_vals[w/2]};
        end
        return 1'b1;
    endfunction

    // Random sample: full scale, small values for ties, or anything
    function automatic logic [31:0] pick_sample();
        int small_val;
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3, 4: begin
                small_val = $urandom_range(0, 8);
                return 32'(small_val - 4);
            end
            default: return $urandom();
        endcase
    endfunction

    // Offer one sample beat and log the expected median once it is taken
    task automatic send_sample(input logic [31:0] smp, input logic restart,
                               input logic known, input logic [MEDIAN_W-1:0] want);
        logic signed [MEDIAN_W-1:0] mx2;
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_sample  <= smp;
        i_restart <= restart;
        i_valid   <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        if (slide_window(smp, restart, mx2)) begin
            pending_medians.push_back(known ? $signed(want) : mx2);
        end
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_medians.size() != 0) @(negedge i_clk);
    endtask

    // Register write at an idle point, then read back the window size
    task automatic settle_and_write(input logic idx, input logic [APB_DW-1:0] val);
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_WINDOW) begin
            win_size_reg = val[WIN_W-1:0];
        end
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {REG_WINDOW, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DW'(win_size_reg)) begin
            $error("window_size readback: expected %0d, got %0d", win_size_reg, prdata);
            error_cnt++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random stall bursts on i_ready
    always @(negedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            i_ready       <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            rx_stall_left <= $urandom_range(0, 2);
            i_ready       <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest expected median
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_medians.size() == 0) begin
                $error("median_x2: unexpected beat, got %0d", o_median_x2);
                error_cnt++;
            end else if (o_median_x2 !== pending_medians[0]) begin
                $error("median_x2 mismatch: expected %0d, got %0d",
                       pending_medians[0], o_median_x2);
                error_cnt++;
                void'(pending_medians.pop_front());
            end else begin
                void'(pending_medians.pop_front());
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** sliding_window_median: FAILED **");
            $finish;
        end
    end

    initial begin
        int ph;
        int n;
        int k;
        logic [APB_DW-1:0] win_word;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_sample      = '0;
        i_restart     = 1'b0;
        i_ready       = 1'b1;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_cnt     = 0;
        cycle_cnt     = 0;
        rx_stall_left = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        win_fill      = 0;
        win_size_reg  = WIN_RESET;
        for (n = 0; n < MAX_W; n++) begin
            win_vals[n] = '0;
            win_age[n]  = 0;
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (k = 0; k < NUM_ROWS; k++) begin
            if (DIRECTED[k].kind == ROW_REG) begin
                settle_and_write(DIRECTED[k].reg_idx, DIRECTED[k].data);
            end else begin
                send_sample(DIRECTED[k].data, DIRECTED[k].restart,
                            DIRECTED[k].known, DIRECTED[k].want);
            end
        end

        // random phases, each under its own window size; the tail runs without idling
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            win_word = $urandom();
            win_word[WIN_W-1:0] = (ph < FIXED_WINS) ? WIN_W'(PHASE_WIN[ph])
                                                    : WIN_W'($urandom_range(0, 31));
            settle_and_write(REG_WINDOW, win_word);
            tx_idle_on = (ph < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (ph < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PAUSE_AT) begin
                    drain_results();
                end
                send_sample(pick_sample(), ($urandom_range(0, 39) == 0), 1'b0, '0);
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_cnt == 0) begin
            $display("** sliding_window_median: PASSED **");
        end else begin
            $display("** sliding_window_median: FAILED **");
        end
        $finish;
    end

endmodule
